// File: hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hdl/mlht_pkg.sv
package mlht_pkg;

   // table geometry
   localparam int BUCKETS = 256;
   localparam int WAYS    = 4;
   localparam int ENTRIES = BUCKETS * WAYS;
   localparam int BKT_W   = $clog2(BUCKETS);
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int FILL_W  = $clog2(WAYS + 1);

   // field widths
   localparam int MAC_W      = 48;
   localparam int PORT_W     = 4;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 8;

   // width of the six-byte sum
   localparam int SUM_W = 11;

   typedef enum logic {
      CMD_LEARN  = 1'b0,
      CMD_LOOKUP = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_ADDED  = 2'd0,
      ST_DUP    = 2'd1,
      ST_FULL   = 2'd2,
      ST_LOOKUP = 2'd3
   } status_type;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      command_type       command;
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
   } key_type;

   // sum of the six address bytes
   function automatic logic [SUM_W-1:0] byte_sum(input logic [MAC_W-1:0] mac);
      logic [SUM_W-1:0] s;
      s = '0;
      for (int i = 0; i < 6; i++) begin
         s = s + SUM_W'(mac[8*i +: 8]);
      end
      return s;
   endfunction

endpackage

// File: hdl/mac_learning_hash_table_unit.sv
// a result comes from scanning the bucket's ways from the newest down, a hit ending the scan
// each way takes one read and one pass through the shared compare unit
// throughput: one item at a time, next item taken the cycle after the result is staged
// reset: synchronous, active high; a clearing pass over every bucket zeroes
//   the fill counts, and no item is accepted until it ends
module mac_learning_hash_table_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mlht_pkg::REQ_DATA_W-1:0] req_tdata,  // mac_address[47:0], port[51:48]
   input  logic                            req_tuser,  // command[0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mlht_pkg::RSP_DATA_W-1:0] rsp_tdata,  // found[0], out_port[4:1]
   output logic [1:0]                      rsp_tuser   // status[1:0]
);
   import mlht_pkg::*;

   typedef enum logic [7:0] {
      S_CLEAR    = 8'b00000001,
      S_IDLE     = 8'b00000010,
      S_FILL_RD  = 8'b00000100,
      S_FILL_GET = 8'b00001000,
      S_SCAN_RD  = 8'b00010000,
      S_SCAN_CMP = 8'b00100000,
      S_WRITE    = 8'b01000000,
      S_RESP     = 8'b10000000
   } state_type;

   state_type         state_ff, state_in;
   logic [BKT_W-1:0]  clr_ff, clr_in;
   key_type           key_ff, key_in;
   logic [BKT_W-1:0]  bucket_ff, bucket_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] way_ff, way_in;
   status_type        res_status_ff, res_status_in;
   logic              res_found_ff, res_found_in;
   logic [PORT_W-1:0] res_port_ff, res_port_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [PORT_W-1:0] rsp_port_ff, rsp_port_in;

   logic              req_take;
   logic              rsp_load;

   logic              fill_wr_en;
   logic [BKT_W-1:0]  fill_wr_addr;
   logic [FILL_W-1:0] fill_wr_data;
   logic [FILL_W-1:0] fill_rd_data;
   logic              ent_wr_en;
   logic [ADDR_W-1:0] ent_wr_addr;
   logic [ADDR_W-1:0] ent_rd_addr;
   entry_type         ent_wr_data;
   entry_type         ent_rd_data;
   logic              way_hit;

   // fill count per bucket
   mlht_ram #(
      .WIDTH (FILL_W),
      .DEPTH (BUCKETS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (fill_wr_addr),
      .wr_data (fill_wr_data),
      .rd_addr (bucket_ff),
      .rd_data (fill_rd_data)
   );

   // address and port per way
   mlht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   // shared way compare
   mlht_match u_match (
      .key   (key_ff),
      .entry (ent_rd_data),
      .hit   (way_hit)
   );

   // memory addressing
   assign ent_rd_addr  = base_ff + ADDR_W'(way_ff - FILL_W'(1));
   assign ent_wr_addr  = base_ff + ADDR_W'(fill_ff);
   assign ent_wr_data  = '{mac: key_ff.mac, port: key_ff.port};
   assign ent_wr_en    = (state_ff == S_WRITE);
   assign fill_wr_en   = (state_ff == S_CLEAR) || (state_ff == S_WRITE);
   assign fill_wr_addr = (state_ff == S_CLEAR) ? clr_ff : bucket_ff;
   assign fill_wr_data = (state_ff == S_CLEAR) ? '0 : (fill_ff + FILL_W'(1));

   // handshakes
   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      key_in        = key_ff;
      bucket_in     = bucket_ff;
      base_in       = base_ff;
      fill_in       = fill_ff;
      way_in        = way_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_port_in   = res_port_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + BKT_W'(1);
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               key_in    = '{command: command_type'(req_tuser),
                             mac:     req_tdata[MAC_W-1:0],
                             port:    req_tdata[MAC_W +: PORT_W]};
               // bucket is the byte sum masked to the bucket count
               bucket_in = BKT_W'(byte_sum(req_tdata[MAC_W-1:0]) % BUCKETS);
               state_in  = S_FILL_RD;
            end
         end
         S_FILL_RD: begin
            base_in  = ADDR_W'(bucket_ff) * ADDR_W'(WAYS);
            state_in = S_FILL_GET;
         end
         S_FILL_GET: begin
            fill_in  = fill_rd_data;
            way_in   = fill_rd_data;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (way_ff == '0) begin
               res_found_in = 1'b0;
               res_port_in  = '0;
               if (key_ff.command == CMD_LOOKUP) begin
                  res_status_in = ST_LOOKUP;
                  state_in      = S_RESP;
               end else if (fill_ff == FILL_W'(WAYS)) begin
                  res_status_in = ST_FULL;
                  state_in      = S_RESP;
               end else begin
                  res_status_in = ST_ADDED;
                  state_in      = S_WRITE;
               end
            end else begin
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (way_hit) begin
               state_in = S_RESP;
               if (key_ff.command == CMD_LOOKUP) begin
                  res_status_in = ST_LOOKUP;
                  res_found_in  = 1'b1;
                  res_port_in   = ent_rd_data.port;
               end else begin
                  res_status_in = ST_DUP;
                  res_found_in  = 1'b0;
                  res_port_in   = '0;
               end
            end else begin
               way_in   = way_ff - FILL_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_WRITE: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output stage
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_status_in = res_status_ff;
         rsp_found_in  = res_found_ff;
         rsp_port_in   = res_port_ff;
         rsp_valid_in  = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      bucket_ff     <= bucket_in;
      base_ff       <= base_in;
      fill_ff       <= fill_in;
      way_ff        <= way_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_port_ff   <= res_port_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_port_ff   <= rsp_port_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_DATA_W - PORT_W - 1)'(0), rsp_port_ff, rsp_found_ff};

endmodule

// File: hdl/mlht_ram.sv
module mlht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mlht_match.sv
module mlht_match (
   input  mlht_pkg::key_type   key,
   input  mlht_pkg::entry_type entry,
   output logic                hit
);
   import mlht_pkg::*;

   // learn checks the port, lookup checks the address
   always_comb begin
      unique case (key.command)
         CMD_LEARN:  hit = (entry.port == key.port);
         CMD_LOOKUP: hit = (entry.mac == key.mac);
      endcase
   end

endmodule

// File: hdl/mlht_checker.sv
`include "assert_macros.svh"

module mlht_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [mlht_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mlht_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                      rsp_tuser
);
   import mlht_pkg::*;

   // a stalled item holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // the table is busy right after taking an item
   `ASSERT_NEXT(a_busy_after_take, clock, reset, req_tvalid && req_tready, !req_tready)

   // learn results carry no hit and no port
   `ASSERT_SAME(a_learn_clean, clock, reset, rsp_tvalid && (rsp_tuser != ST_LOOKUP), rsp_tdata == '0)

   // a result with no hit, lookup miss or learn, reports port zero
   `ASSERT_SAME(a_miss_port, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[PORT_W:1] == '0)

endmodule

bind mac_learning_hash_table_unit mlht_checker u_mlht_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mlht_pkg::*;

   // one forwarding result as the block reports it
   typedef struct packed {
      status_type       status;
      logic             found;
      logic [PORT_W-1:0] out_port;
   } fwd_result_type;

   // one directed item, with a typed-in result where it is obvious
   typedef struct packed {
      command_type       command;
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
      logic              typed;
      fwd_result_type    result;
   } directed_row_type;

   typedef enum int {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_PATTERN
   } ready_mode_type;

   localparam int N_DIRECTED = 21;
   localparam int N_RANDOM   = 1400;
   localparam int HOT_BUCKETS = 16;

   // bucket 0 is filled by addresses whose bytes sum to 0 or 256
   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      '{CMD_LOOKUP, 48'h0000_0000_0000, 4'h0, 1'b1, '{ST_LOOKUP, 1'b0, 4'h0}},
      '{CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'hF, 1'b1, '{ST_LOOKUP, 1'b0, 4'h0}},
      '{CMD_LEARN,  48'h0000_0000_0000, 4'h0, 1'b1, '{ST_ADDED,  1'b0, 4'h0}},
      '{CMD_LEARN,  48'hFFFF_FFFF_FFFF, 4'hF, 1'b1, '{ST_ADDED,  1'b0, 4'h0}},
      '{CMD_LOOKUP, 48'h0000_0000_0000, 4'h0, 1'b1, '{ST_LOOKUP, 1'b1, 4'h0}},
      '{CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 4'h0, 1'b1, '{ST_LOOKUP, 1'b1, 4'hF}},
      '{CMD_LEARN,  48'h0000_0000_0000, 4'h0, 1'b1, '{ST_DUP,    1'b0, 4'h0}},
      '{CMD_LEARN,  48'h0000_0000_01FF, 4'h0, 1'b1, '{ST_DUP,    1'b0, 4'h0}},
      '{CMD_LEARN,  48'h0000_0000_01FF, 4'h3, 1'b1, '{ST_ADDED,  1'b0, 4'h0}},
      '{CMD_LEARN,  48'h0000_0000_0000, 4'h5, 1'b1, '{ST_ADDED,  1'b0, 4'h0}},
      '{CMD_LOOKUP, 48'h0000_0000_0000, 4'h0, 1'b1, '{ST_LOOKUP, 1'b1, 4'h5}},
      '{CMD_LEARN,  48'h0000_0000_02FE, 4'h7, 1'b1, '{ST_ADDED,  1'b0, 4'h0}},
      '{CMD_LEARN,  48'h0000_0000_03FD, 4'h9, 1'b1, '{ST_FULL,   1'b0, 4'h0}},
      '{CMD_LEARN,  48'h0000_0000_03FD, 4'h7, 1'b1, '{ST_DUP,    1'b0, 4'h0}},
      '{CMD_LOOKUP, 48'h0000_0000_01FF, 4'h0, 1'b0, '{ST_ADDED,  1'b0, 4'h0}},
      '{CMD_LOOKUP, 48'h0000_0000_03FD, 4'h0, 1'b1, '{ST_LOOKUP, 1'b0, 4'h0}},
      '{CMD_LOOKUP, 48'h0000_0000_0000, 4'hF, 1'b1, '{ST_LOOKUP, 1'b1, 4'h5}},
      '{CMD_LEARN,  48'h8000_0000_0000, 4'h8, 1'b0, '{ST_ADDED,  1'b0, 4'h0}},
      '{CMD_LOOKUP, 48'h8000_0000_0000, 4'h0, 1'b0, '{ST_ADDED,  1'b0, 4'h0}},
      '{CMD_LEARN,  48'h0000_0000_00FF, 4'hF, 1'b0, '{ST_ADDED,  1'b0, 4'h0}},
      '{CMD_LOOKUP, 48'h0000_0000_00FF, 4'h0, 1'b0, '{ST_ADDED,  1'b0, 4'h0}}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // mac_address[47:0], port[51:48]
   logic                  req_tuser  = 1'b0;  // command[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // found[0], out_port[4:1]
   logic [1:0]            rsp_tuser;  // status[1:0]

   // shadow forwarding table
   logic [MAC_W-1:0]  shadow_mac  [BUCKETS][WAYS];
   logic [PORT_W-1:0] shadow_port [BUCKETS][WAYS];
   int unsigned       shadow_fill [BUCKETS];

   fwd_result_type   pending_results [$];
   logic [MAC_W-1:0] learned_macs [$];
   int               mismatch_count = 0;

   mac_learning_hash_table_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // byte sum of the address, reduced to a bucket
   function automatic int unsigned bucket_of_mac(input logic [MAC_W-1:0] mac);
      int unsigned total;
      total = 0;
      for (int i = 0; i < 6; i++) begin
         total += 32'(mac[8*i +: 8]);
      end
      return total % BUCKETS;
   endfunction

   // random address whose low byte is picked to land in the given bucket
   function automatic logic [MAC_W-1:0] mac_in_bucket(input int unsigned target);
      logic [MAC_W-1:0] mac;
      int unsigned      upper;
      mac[47:16] = $urandom;
      mac[15:0]  = 16'($urandom);
      upper = 0;
      for (int i = 1; i < 6; i++) begin
         upper += 32'(mac[8*i +: 8]);
      end
      mac[7:0] = 8'(target - upper);
      return mac;
   endfunction

   // learn or look up against the shadow table, updating it on an add
   function automatic fwd_result_type forward_table_access(input command_type      command,
                                                           input logic [MAC_W-1:0]  mac,
                                                           input logic [PORT_W-1:0] port);
      fwd_result_type r;
      int unsigned    b;
      int unsigned    n;
      int             w;
      logic           hit;
      r   = '{ST_ADDED, 1'b0, '0};
      b   = bucket_of_mac(mac);
      n   = shadow_fill[b];
      hit = 1'b0;
      if (command == CMD_LEARN) begin
         for (int k = 0; k < n; k++) begin
            if (shadow_port[b][k] == port) hit = 1'b1;
         end
         if (hit) begin
            r.status = ST_DUP;
         end else if (n >= WAYS) begin
            r.status = ST_FULL;
         end else begin
            shadow_mac[b][n]  = mac;
            shadow_port[b][n] = port;
            shadow_fill[b]    = n + 1;
         end
      end else begin
         // newest entry first
         r.status = ST_LOOKUP;
         w = n;
         while (w > 0 && !hit) begin
            w--;
            if (shadow_mac[b][w] == mac) begin
               hit        = 1'b1;
               r.found    = 1'b1;
               r.out_port = shadow_port[b][w];
            end
         end
      end
      return r;
   endfunction

   // present one item, wait for its acceptance, then queue its result
   task automatic send_item(input command_type      command,
                            input logic [MAC_W-1:0]  mac,
                            input logic [PORT_W-1:0] port,
                            input logic              typed,
                            input fwd_result_type    typed_result);
      fwd_result_type predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-MAC_W-PORT_W){1'b0}}, port, mac};
      req_tuser  <= command;
      do @(posedge clock); while (!req_tready);
      predicted = forward_table_access(command, mac, port);
      pending_results.push_back(typed ? typed_result : predicted);
      if (command == CMD_LEARN && predicted.status == ST_ADDED) learned_macs.push_back(mac);
   endtask

   task automatic drain_results();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      command_type      command;
      logic [MAC_W-1:0] mac;
      int               sent;
      int               burst;
      int               gap;
      int unsigned      pick;

      foreach (shadow_fill[b]) shadow_fill[b] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, back to back
      foreach (DIRECTED[i]) begin
         send_item(DIRECTED[i].command, DIRECTED[i].mac, DIRECTED[i].port,
                   DIRECTED[i].typed, DIRECTED[i].result);
      end
      req_tvalid <= 1'b0;
      drain_results();

      // random part in bursts
      sent = 0;
      while (sent < N_RANDOM) begin
         if ($urandom_range(0, 59) == 0) begin
            req_tvalid <= 1'b0;
            drain_results();
         end
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               // learn: fresh address in a hot or any bucket, or a known one
               command = CMD_LEARN;
               if (learned_macs.size() != 0 && $urandom_range(0, 3) == 0)
                  mac = learned_macs[$urandom_range(0, learned_macs.size() - 1)];
               else if ($urandom_range(0, 9) < 4)
                  mac = mac_in_bucket($urandom_range(0, HOT_BUCKETS - 1));
               else
                  mac = mac_in_bucket($urandom_range(0, BUCKETS - 1));
            end else begin
               // lookup: mostly known addresses, some fresh ones in a hot or any bucket
               command = CMD_LOOKUP;
               if (learned_macs.size() != 0 && $urandom_range(0, 9) < 7)
                  mac = learned_macs[$urandom_range(0, learned_macs.size() - 1)];
               else if ($urandom_range(0, 1) == 0)
                  mac = mac_in_bucket($urandom_range(0, HOT_BUCKETS - 1));
               else
                  mac = mac_in_bucket($urandom_range(0, BUCKETS - 1));
            end
            send_item(command, mac, PORT_W'($urandom_range(0, 15)), 1'b0, '0);
            sent++;
         end
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      // let the last results come out, then a little longer
      drain_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // result side: check accepted items, stall on a changing pattern
   ready_mode_type ready_mode  = RDY_ALWAYS;
   int             ready_count = 0;

   always @(posedge clock) begin
      fwd_result_type exp_result;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("result item with no expectation waiting");
               mismatch_count++;
            end else begin
               exp_result = pending_results.pop_front();
               if (rsp_tuser !== exp_result.status) begin
                  $error("status: expected %0d, actual %0d", exp_result.status, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata[0] !== exp_result.found) begin
                  $error("found: expected %0d, actual %0d", exp_result.found, rsp_tdata[0]);
                  mismatch_count++;
               end
               if (rsp_tdata[4:1] !== exp_result.out_port) begin
                  $error("out_port: expected %0d, actual %0d",
                         exp_result.out_port, rsp_tdata[4:1]);
                  mismatch_count++;
               end
            end
         end
         // switch stall mode at random, driven by the cycle counter
         ready_count <= ready_count + 1;
         if (ready_count % 200 == 199) ready_mode <= ready_mode_type'($urandom_range(0, 2));
         case (ready_mode)
            RDY_ALWAYS:  rsp_tready <= 1'b1;
            RDY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
            default:     rsp_tready <= (ready_count % 7) < 2;
         endcase
      end
   end

   // overall time limit
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mlht_pkg.sv
hdl/mlht_ram.sv
hdl/mlht_match.sv
hdl/mac_learning_hash_table_unit.sv
hdl/mlht_checker.sv
tb/sv/tb_top.sv
